@@ src/sacl_pkg.sv @@
// Shared constants, types and width helpers for the set-associative tag directory.
package sacl_pkg;

  // Fixed field widths of the item ports.
  localparam int ADDR_W      = 32;
  localparam int WAY_FIELD_W = 2;
  localparam int STAMP_W     = 32;
  localparam int COUNT_W     = 32;

  // Default geometry.
  localparam int DEF_BLOCK_WORDS  = 64;
  localparam int DEF_SETS         = 4;
  localparam int DEF_WAYS         = 4;
  localparam int DEF_ADDRESS_BITS = 32;

  // Depth of the queue between the front and the back.
  localparam int QUEUE_DEPTH = 2;

  typedef logic [ADDR_W-1:0]      addr_t;
  typedef logic [STAMP_W-1:0]     stamp_t;
  typedef logic [COUNT_W-1:0]     count_t;
  typedef logic [WAY_FIELD_W-1:0] way_field_t;

  // Address bits that take part in the lookup.
  function automatic int eff_width(int address_bits);
    return (address_bits < ADDR_W) ? address_bits : ADDR_W;
  endfunction

  // Width of a set index vector (at least one bit).
  function automatic int set_width(int sets);
    return (sets > 1) ? $clog2(sets) : 1;
  endfunction

  // Width of a way number vector (at least one bit).
  function automatic int way_width(int ways);
    return (ways > 1) ? $clog2(ways) : 1;
  endfunction

  // Width of a stored tag (at least one bit).
  function automatic int tag_width(int block_words, int sets, int address_bits);
    int raw;
    raw = eff_width(address_bits) - $clog2(block_words) - $clog2(sets);
    return (raw > 0) ? raw : 1;
  endfunction

endpackage

@@ src/sacl_ifs.sv @@
// Handshake interfaces for the address items and the lookup result items.
interface sacl_req_if;
  import sacl_pkg::*;
  logic  valid;
  logic  ready;
  addr_t address;

  modport source (output valid, output address, input ready);
  modport sink   (input valid, input address, output ready);
endinterface

interface sacl_rsp_if;
  import sacl_pkg::*;
  logic       valid;
  logic       ready;
  logic       hit;
  way_field_t way;
  logic       evicted_valid;
  count_t     access_total;
  count_t     miss_total;

  modport source (output valid, output hit, output way, output evicted_valid,
                  output access_total, output miss_total, input ready);
  modport sink   (input valid, input hit, input way, input evicted_valid,
                  input access_total, input miss_total, output ready);
endinterface

@@ src/set_assoc_cache_lru_mru_unit.sv @@
// Flow: an accepted item waits in the queue; the back end pops it, reads its set row from the
// directory RAM and compares the tags, then writes the row back and loads the output register.
// A miss in a full set first weighs the ways, one victim candidate per cycle. No new item is
// popped until the last is issued; the row passes through the directory RAM's single port pair.
// Reset: synchronous; a clearing pass invalidates every row, and no item is accepted until it
// ends. The policy register resets to least-recently-used replacement.
module set_assoc_cache_lru_mru_unit import sacl_pkg::*; #(
  parameter int BLOCK_WORDS  = DEF_BLOCK_WORDS,
  parameter int SETS         = DEF_SETS,
  parameter int WAYS         = DEF_WAYS,
  parameter int ADDRESS_BITS = DEF_ADDRESS_BITS
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write,
  input  logic       cfg_data,
  sacl_req_if.sink   req,
  sacl_rsp_if.source rsp
);

  localparam int SET_IW  = set_width(SETS);
  localparam int TAG_W   = tag_width(BLOCK_WORDS, SETS, ADDRESS_BITS);
  localparam int ENTRY_W = TAG_W + SET_IW;

  logic               replace_least_recent;
  logic               clear_done;
  logic               q_full;
  logic               push;
  logic [ENTRY_W-1:0] push_data;
  logic               q_valid;
  logic               pop;
  logic [ENTRY_W-1:0] q_data;

  // Replacement policy register.
  always_ff @(posedge clk) begin
    if (rst) begin
      replace_least_recent <= 1'b1;
    end else if (cfg_write) begin
      replace_least_recent <= cfg_data;
    end
  end

  sacl_front #(
    .BLOCK_WORDS  (BLOCK_WORDS),
    .SETS         (SETS),
    .ADDRESS_BITS (ADDRESS_BITS)
  ) u_front (
    .req        (req),
    .clear_done (clear_done),
    .q_full     (q_full),
    .push       (push),
    .push_data  (push_data)
  );

  sacl_queue #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .pop_data  (q_data),
    .not_empty (q_valid)
  );

  sacl_back #(
    .BLOCK_WORDS  (BLOCK_WORDS),
    .SETS         (SETS),
    .WAYS         (WAYS),
    .ADDRESS_BITS (ADDRESS_BITS)
  ) u_back (
    .clk                  (clk),
    .rst                  (rst),
    .replace_least_recent (replace_least_recent),
    .q_valid              (q_valid),
    .q_data               (q_data),
    .pop                  (pop),
    .clear_done           (clear_done),
    .rsp                  (rsp)
  );

endmodule

@@ src/sacl_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module sacl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ src/sacl_queue.sv @@
// Short FIFO that decouples the classifying front from the lookup back end.
module sacl_queue import sacl_pkg::*; #(
  parameter int WIDTH = 8,
  parameter int DEPTH = QUEUE_DEPTH,
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             not_empty
);

  logic [WIDTH-1:0] entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full      = (count == CNT_W'(DEPTH));
  assign not_empty = (count != '0);
  assign pop_data  = entries[rd_ptr];

  // Storage is written at the tail.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ src/sacl_front.sv @@
// Front end: accepts address items and splits them into set index and tag.
module sacl_front import sacl_pkg::*; #(
  parameter int BLOCK_WORDS  = DEF_BLOCK_WORDS,
  parameter int SETS         = DEF_SETS,
  parameter int ADDRESS_BITS = DEF_ADDRESS_BITS,
  localparam int EFF_W   = eff_width(ADDRESS_BITS),
  localparam int OFF_W   = $clog2(BLOCK_WORDS),
  localparam int SET_SH  = $clog2(SETS),
  localparam int SET_IW  = set_width(SETS),
  localparam int TAG_W   = tag_width(BLOCK_WORDS, SETS, ADDRESS_BITS),
  localparam int ENTRY_W = TAG_W + SET_IW
) (
  sacl_req_if.sink            req,
  input  logic                clear_done,
  input  logic                q_full,
  output logic                push,
  output logic [ENTRY_W-1:0]  push_data
);

  localparam addr_t CUT_MASK = addr_t'((64'd1 << EFF_W) - 64'd1);
  localparam addr_t SET_MASK = addr_t'(SETS - 1);

  addr_t             cut_addr;
  logic [SET_IW-1:0] set_idx;
  logic [TAG_W-1:0]  tag;

  // Cut the address to its lookup width, then take it apart.
  always_comb begin
    cut_addr = req.address & CUT_MASK;
    set_idx  = SET_IW'((cut_addr >> OFF_W) & SET_MASK);
    tag      = TAG_W'(cut_addr >> (OFF_W + SET_SH));
  end

  // Items are taken once the directory is cleared and the queue has room.
  assign req.ready = clear_done & ~q_full;
  assign push      = req.valid & req.ready;
  assign push_data = {tag, set_idx};

endmodule

@@ src/sacl_back.sv @@
// Back end: reads a set row, resolves hit or victim, updates the row and issues the result.
module sacl_back import sacl_pkg::*; #(
  parameter int BLOCK_WORDS  = DEF_BLOCK_WORDS,
  parameter int SETS         = DEF_SETS,
  parameter int WAYS         = DEF_WAYS,
  parameter int ADDRESS_BITS = DEF_ADDRESS_BITS,
  localparam int SET_IW  = set_width(SETS),
  localparam int TAG_W   = tag_width(BLOCK_WORDS, SETS, ADDRESS_BITS),
  localparam int WAY_W   = way_width(WAYS),
  localparam int ENTRY_W = TAG_W + SET_IW,
  localparam int ROW_W   = WAYS * (1 + TAG_W + STAMP_W)
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               replace_least_recent,
  input  logic               q_valid,
  input  logic [ENTRY_W-1:0] q_data,
  output logic               pop,
  output logic               clear_done,
  sacl_rsp_if.source         rsp
);

  localparam int TAG_BASE   = WAYS;
  localparam int STAMP_BASE = WAYS + WAYS * TAG_W;

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_LOOK   = 3'd2;
  localparam logic [2:0] S_SEARCH = 3'd3;
  localparam logic [2:0] S_FIN    = 3'd4;

  logic [2:0]        state;
  logic [SET_IW-1:0] clr_cnt;
  logic [SET_IW-1:0] cur_set;
  logic [TAG_W-1:0]  cur_tag;
  logic [ROW_W-1:0]  row_reg;
  logic [WAY_W-1:0]  idx;
  logic [WAY_W-1:0]  best;
  stamp_t            best_stamp;
  logic [WAY_W-1:0]  fin_way;
  logic              fin_hit;
  logic              fin_evict;
  count_t            access_count;
  count_t            miss_count;
  logic              out_valid;

  logic [ROW_W-1:0]  rdata;
  logic              ram_we;
  logic [SET_IW-1:0] ram_waddr;
  logic [ROW_W-1:0]  ram_wdata;
  logic [ROW_W-1:0]  new_row;

  logic              rd_valid [WAYS];
  logic [TAG_W-1:0]  rd_tag   [WAYS];
  stamp_t            rr_stamp [WAYS];

  logic              hit_any;
  logic [WAY_W-1:0]  hit_way;
  logic              empty_any;
  logic [WAY_W-1:0]  empty_way;
  stamp_t            cand;
  logic              better;
  logic              out_free;
  logic              finish;
  count_t            access_next;

  // One row per set: valid bits, tags and timestamps of all ways.
  sacl_ram #(
    .WIDTH (ROW_W),
    .DEPTH (SETS)
  ) u_dir (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (pop),
    .raddr (q_data[SET_IW-1:0]),
    .rdata (rdata)
  );

  // Unpack the freshly read row and the held row.
  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      rd_valid[w] = rdata[w];
      rd_tag[w]   = rdata[TAG_BASE + w*TAG_W +: TAG_W];
      rr_stamp[w] = row_reg[STAMP_BASE + w*STAMP_W +: STAMP_W];
    end
  end

  // Parallel tag compare and first-invalid search; the lowest way wins.
  always_comb begin
    hit_any   = 1'b0;
    hit_way   = '0;
    empty_any = 1'b0;
    empty_way = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (rd_valid[w] && (rd_tag[w] == cur_tag)) begin
        hit_any = 1'b1;
        hit_way = WAY_W'(w);
      end
      if (!rd_valid[w]) begin
        empty_any = 1'b1;
        empty_way = WAY_W'(w);
      end
    end
  end

  // One victim candidate is weighed per cycle; ties keep the earlier way.
  always_comb begin
    cand   = rr_stamp[idx];
    better = replace_least_recent ? (cand < best_stamp) : (cand > best_stamp);
  end

  // Updated row: the chosen way becomes valid with the new tag and stamp.
  assign access_next = access_count + 1'b1;

  always_comb begin
    new_row = row_reg;
    for (int w = 0; w < WAYS; w++) begin
      if (WAY_W'(w) == fin_way) begin
        new_row[w]                                = 1'b1;
        new_row[TAG_BASE + w*TAG_W +: TAG_W]       = cur_tag;
        new_row[STAMP_BASE + w*STAMP_W +: STAMP_W] = access_next;
      end
    end
  end

  assign out_free   = ~out_valid | rsp.ready;
  assign finish     = (state == S_FIN) && out_free;
  assign pop        = (state == S_IDLE) && q_valid;
  assign clear_done = (state != S_CLEAR);

  // RAM write: clearing pass after reset, row update at the end of an item.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cur_set;
    ram_wdata = new_row;
    case (state)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_cnt;
        ram_wdata = '0;
      end
      S_FIN: begin
        ram_we = out_free;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      clr_cnt <= '0;
    end else begin
      case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == SET_IW'(SETS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (q_valid) begin
            state <= S_LOOK;
          end
        end
        S_LOOK: begin
          if (hit_any || empty_any || (WAYS == 1)) begin
            state <= S_FIN;
          end else begin
            state <= S_SEARCH;
          end
        end
        S_SEARCH: begin
          if (idx == WAY_W'(WAYS - 1)) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Per-item working registers.
  always_ff @(posedge clk) begin
    if (pop) begin
      cur_set <= q_data[SET_IW-1:0];
      cur_tag <= q_data[SET_IW +: TAG_W];
    end
    if (state == S_LOOK) begin
      row_reg    <= rdata;
      idx        <= WAY_W'(1);
      best       <= '0;
      best_stamp <= rdata[STAMP_BASE +: STAMP_W];
      fin_hit    <= hit_any;
      fin_evict  <= ~hit_any & ~empty_any;
      fin_way    <= hit_any ? hit_way : (empty_any ? empty_way : '0);
    end
    if (state == S_SEARCH) begin
      idx <= idx + 1'b1;
      if (better) begin
        best       <= idx;
        best_stamp <= cand;
      end
      if (idx == WAY_W'(WAYS - 1)) begin
        fin_way <= better ? idx : best;
      end
    end
  end

  // Counters and the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      access_count <= '0;
      miss_count   <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (rsp.ready) begin
        out_valid <= 1'b0;
      end
      if (finish) begin
        access_count <= access_next;
        if (!fin_hit) begin
          miss_count <= miss_count + 1'b1;
        end
        out_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      rsp.hit           <= fin_hit;
      rsp.way           <= way_field_t'(fin_way);
      rsp.evicted_valid <= fin_evict;
      rsp.access_total  <= access_next;
      rsp.miss_total    <= fin_hit ? miss_count : miss_count + 1'b1;
    end
  end

  assign rsp.valid = out_valid;

endmodule
